@@ src/bst_pkg.sv @@
package bst_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int CFG_W       = 5;
    localparam int VALUE_W     = 32;
    localparam int IDX_FIELD_W = 4;
    localparam int POS_W       = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // input tdata: entry_index, entry_value, search_key, zero pad
    localparam int IN_DATA_BITS = IDX_FIELD_W + 2 * VALUE_W;
    localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int IDX_LSB      = 0;
    localparam int VALUE_LSB    = IDX_LSB + IDX_FIELD_W;
    localparam int KEY_LSB      = VALUE_LSB + VALUE_W;

    // output tdata: found, position, zero pad
    localparam int OUT_DATA_BITS = 1 + POS_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic range_done;
    } status_t;

endpackage

@@ src/bst_ram.sv @@
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bst_datapath.sv @@
module bst_datapath #(
    parameter int TABLE_DEPTH = bst_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bst_pkg::cmd_t                  cmd,
    output bst_pkg::status_t               status,
    input  logic                           cfg_we,
    input  logic [bst_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [bst_pkg::IN_TDATA_W-1:0] in_tdata,
    output logic [bst_pkg::OUT_TDATA_W-1:0] out_tdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PTR_W  = bst_pkg::CFG_W;

    logic [PTR_W-1:0]                entries_in_use_reg;
    logic [PTR_W-1:0]                count;
    logic [bst_pkg::IDX_FIELD_W-1:0] in_idx;
    logic signed [bst_pkg::VALUE_W-1:0] in_value;
    logic signed [bst_pkg::VALUE_W-1:0] in_key;

    logic [PTR_W-1:0] low_reg, low_next;
    logic [PTR_W-1:0] hi_reg, hi_next;
    logic [PTR_W-1:0] mid_reg, mid_next;
    logic signed [bst_pkg::VALUE_W-1:0] key_reg;
    logic             found_reg;
    logic [bst_pkg::POS_W-1:0] pos_reg;
    logic             out_found_reg;
    logic [bst_pkg::POS_W-1:0] out_pos_reg;

    logic [PTR_W:0]   mid_sum;
    logic             hit;
    logic             ram_we;
    logic signed [bst_pkg::VALUE_W-1:0] rdata;

    assign in_idx   = in_tdata[bst_pkg::IDX_LSB +: bst_pkg::IDX_FIELD_W];
    assign in_value = in_tdata[bst_pkg::VALUE_LSB +: bst_pkg::VALUE_W];
    assign in_key   = in_tdata[bst_pkg::KEY_LSB +: bst_pkg::VALUE_W];

    // a count above the table depth searches the whole table
    assign count = (32'(entries_in_use_reg) > TABLE_DEPTH) ? PTR_W'(TABLE_DEPTH)
                                                           : entries_in_use_reg;

    assign ram_we = cmd.write && (32'(in_idx) < TABLE_DEPTH);

    // range is [low, hi) with hi exclusive
    always_comb
    begin
        hit      = 1'b0;
        low_next = low_reg;
        hi_next  = hi_reg;
        if (cmd.start)
        begin
            low_next = '0;
            hi_next  = count;
        end
        else if (rdata == key_reg)
        begin
            hit = 1'b1;
        end
        else if (rdata > key_reg)
        begin
            hi_next = mid_reg;
        end
        else
        begin
            low_next = mid_reg + PTR_W'(1);
        end
        mid_sum  = (PTR_W+1)'(low_next) + (PTR_W+1)'(hi_next) - (PTR_W+1)'(1);
        mid_next = mid_sum[PTR_W:1];
    end

    assign status.range_done = hit || (low_next >= hi_next);

    bst_ram #(
        .WIDTH(bst_pkg::VALUE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ADDR_W'(in_idx)),
        .wdata(in_value),
        .raddr(ADDR_W'(mid_next)),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= bst_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            entries_in_use_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg   <= in_key;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (cmd.step && hit)
        begin
            found_reg <= 1'b1;
            pos_reg   <= bst_pkg::POS_W'(mid_reg);
        end
        if (cmd.start || cmd.step)
        begin
            low_reg <= low_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (cmd.load_out)
        begin
            out_found_reg <= found_reg;
            out_pos_reg   <= pos_reg;
        end
    end

    assign out_tdata = {{(bst_pkg::OUT_TDATA_W - bst_pkg::OUT_DATA_BITS){1'b0}},
                        out_pos_reg, out_found_reg};

endmodule

@@ src/bst_ctrl.sv @@
module bst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output bst_pkg::cmd_t    cmd,
    input  bst_pkg::status_t status
);

    bst_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_xfer;
    logic            out_free;

    assign s_tready = (state_reg == bst_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.write    = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            bst_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == bst_pkg::OP_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        // an empty range goes straight to the answer
                        state_next = status.range_done ? bst_pkg::ST_DONE
                                                       : bst_pkg::ST_PROBE;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            bst_pkg::ST_PROBE:
            begin
                cmd.step = 1'b1;
                if (status.range_done)
                begin
                    state_next = bst_pkg::ST_DONE;
                end
            end
            bst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = bst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register loaded while holding an untaken result");

    a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == bst_pkg::OP_SEARCH) |=> !s_tready)
        else $error("input taken while a search is running");

    a_probe_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bst_pkg::ST_PROBE && status.range_done)
            |=> state_reg == bst_pkg::ST_DONE)
        else $error("search did not finish when range closed");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == bst_pkg::ST_DONE)
        else $error("result raised outside of the done state");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> state_reg == bst_pkg::ST_IDLE)
        else $error("write transfer left the idle state");
`endif

endmodule

@@ src/binary_search_sorted_table.sv @@
// binary search over a sorted table of signed 32-bit entries
// write transfer: no result, the block stays idle; search: a run of table probes
// on a search, m_tvalid rises after probing ends and the done state loads the result
// s_tready stays low until then; done holds while an untaken result waits on m_tready
// probes = floor(log2(count)) + 1 at most, one registered ram read per cycle
// rst_n is asynchronous, active low; clears control and sets entries_in_use to 16
// table contents are undefined after reset until written
module binary_search_sorted_table #(
    parameter int TABLE_DEPTH = bst_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bst_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index [3:0], entry_value [35:4], search_key [67:36], zero pad
    input  logic [bst_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found [0], position [4:1], zero pad
    output logic [bst_pkg::OUT_TDATA_W-1:0] m_tdata
);

    bst_pkg::cmd_t    cmd;
    bst_pkg::status_t status;

    bst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .status  (status)
    );

    bst_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_tdata (s_tdata),
        .out_tdata(m_tdata)
    );

endmodule
